>>> hdl/cdpm_pkg.sv
// ----------------------------------------------------------------------------
// cdpm_pkg: shared types and constants
// Widths, the per-mille scale, the job word passed from the front end to the
// divider and the divider state type.
// ----------------------------------------------------------------------------
`default_nettype none

package cdpm_pkg;

    localparam int MAX_ENTRIES_DEF = 16;
    localparam int SAMPLE_W        = 32;
    localparam int TOTAL_W         = 36;
    localparam int SHARE_W         = 10;
    localparam int SCALE_W         = 10;
    localparam int NUM_W           = 42;
    localparam int STEP_W          = 6;

    localparam logic [SCALE_W-1:0] PER_MILLE   = SCALE_W'(1000);
    localparam logic [TOTAL_W-1:0] TOTAL_MAX   = {TOTAL_W{1'b1}};
    localparam logic [STEP_W-1:0]  LAST_STEP   = STEP_W'(NUM_W - 1);

    typedef struct packed {
        logic [SAMPLE_W-1:0] change;
        logic [TOTAL_W-1:0]  total;
        logic                last;
    } t_job;

    typedef enum logic [1:0] {
        DS_IDLE,
        DS_RUN,
        DS_DONE
    } t_div_state;

endpackage

`default_nettype wire

>>> hdl/counter_delta_per_mille_shares.sv
// ----------------------------------------------------------------------------
// counter_delta_per_mille_shares: counter change shares in per mille
// Each sample is registered by the front end. After set end, the front end
// walks the changes into the job queue and the divider pops them one at a time;
// the bit-serial divider finishes one share before it takes the next change.
// The front end stays busy while it hands the set to the job queue.
// Reset (synchronous, active low) clears previous samples, the total and all
// control state. The receiver cannot stall: each share is a one-cycle strobe.
// ----------------------------------------------------------------------------
`default_nettype none

module counter_delta_per_mille_shares #(
    parameter int MAX_ENTRIES = cdpm_pkg::MAX_ENTRIES_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [cdpm_pkg::SAMPLE_W-1:0] i_counter_sample,
    input  wire logic                          i_set_end,
    output logic                               o_busy,
    output logic                               o_valid,
    output logic [cdpm_pkg::SHARE_W-1:0]       o_share_per_mille,
    output logic [cdpm_pkg::TOTAL_W-1:0]       o_total_change,
    output logic                               o_run_end
);

    cdpm_pkg::t_job push_job, pop_job;
    logic           push, pop, q_full, q_valid;

    // intake: form changes, total; walk the set into the queue on set end
    cdpm_front #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_start          (i_start),
        .i_counter_sample (i_counter_sample),
        .i_set_end        (i_set_end),
        .i_q_full         (q_full),
        .o_busy           (o_busy),
        .o_push           (push),
        .o_job            (push_job)
    );

    // queue words between intake and divider
    cdpm_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_job   (pop_job)
    );

    // divide each change into a rounded per-mille share
    cdpm_div u_div (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (q_valid),
        .i_job             (pop_job),
        .o_pop             (pop),
        .o_valid           (o_valid),
        .o_share_per_mille (o_share_per_mille),
        .o_total_change    (o_total_change),
        .o_run_end         (o_run_end)
    );

    a_share_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_share_per_mille <= cdpm_pkg::SHARE_W'(1000))
        else $error("share out of range");

    a_total_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_total_change != '0)
        else $error("zero total on output");

    a_close_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && i_set_end) |=> o_busy)
        else $error("set close did not start walk");

endmodule

`default_nettype wire

>>> hdl/cdpm_front.sv
// ----------------------------------------------------------------------------
// cdpm_front: sample intake
// Takes counter samples, forms the wrap-safe change against the previous
// sample, keeps the running total and walks the stored changes into the queue
// once the set closes.
// ----------------------------------------------------------------------------
`default_nettype none

module cdpm_front #(
    parameter int MAX_ENTRIES = cdpm_pkg::MAX_ENTRIES_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [cdpm_pkg::SAMPLE_W-1:0] i_counter_sample,
    input  wire logic                          i_set_end,
    input  wire logic                          i_q_full,
    output logic                               o_busy,
    output logic                               o_push,
    output cdpm_pkg::t_job                     o_job
);

    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam logic [CNT_W-1:0] CAP = CNT_W'(MAX_ENTRIES);

    logic [cdpm_pkg::SAMPLE_W-1:0] r_prev [MAX_ENTRIES];
    logic [cdpm_pkg::SAMPLE_W-1:0] r_chg  [MAX_ENTRIES];
    logic [cdpm_pkg::TOTAL_W-1:0]  r_total, n_total;
    logic [cdpm_pkg::TOTAL_W-1:0]  r_fin, n_fin;
    logic [CNT_W-1:0]              r_idx, n_idx;
    logic [CNT_W-1:0]              r_cnt, n_cnt;
    logic [CNT_W-1:0]              r_wk, n_wk;
    logic                          r_walk, n_walk;

    logic                          accept;
    logic                          store;
    logic [IDX_W-1:0]              pos;
    logic [cdpm_pkg::SAMPLE_W-1:0] delta;
    logic [cdpm_pkg::TOTAL_W:0]    sum;
    logic [cdpm_pkg::TOTAL_W-1:0]  tot_new;

    assign accept = i_start && !r_walk;
    assign store  = accept && (r_idx < CAP);
    assign pos    = r_idx[IDX_W-1:0];
    assign delta  = i_counter_sample - r_prev[pos];
    assign sum    = {1'b0, r_total} + (cdpm_pkg::TOTAL_W + 1)'(delta);
    assign tot_new = sum[cdpm_pkg::TOTAL_W] ? cdpm_pkg::TOTAL_MAX
                                            : sum[cdpm_pkg::TOTAL_W-1:0];

    assign o_busy     = r_walk;
    assign o_push     = r_walk && !i_q_full;
    assign o_job.change = r_chg[r_wk[IDX_W-1:0]];
    assign o_job.total  = r_fin;
    assign o_job.last   = (r_wk + CNT_W'(1)) == r_cnt;

    always_comb begin
        n_total = r_total;
        n_idx   = r_idx;
        n_fin   = r_fin;
        n_cnt   = r_cnt;
        n_wk    = r_wk;
        n_walk  = r_walk;
        if (store) begin
            n_total = tot_new;
            n_idx   = r_idx + CNT_W'(1);
        end
        if (accept && i_set_end) begin
            // close the set: latch count and total, start the walk
            n_cnt   = n_idx;
            n_fin   = (n_total == '0) ? cdpm_pkg::TOTAL_W'(1) : n_total;
            n_wk    = '0;
            n_walk  = 1'b1;
            n_idx   = '0;
            n_total = '0;
        end
        if (o_push) begin
            n_wk = r_wk + CNT_W'(1);
            if (o_job.last) begin
                n_walk = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
            r_idx   <= '0;
            r_walk  <= 1'b0;
            r_wk    <= '0;
            r_cnt   <= '0;
            for (int i = 0; i < MAX_ENTRIES; i++) begin
                r_prev[i] <= '0;
            end
        end else begin
            r_total <= n_total;
            r_idx   <= n_idx;
            r_walk  <= n_walk;
            r_wk    <= n_wk;
            r_cnt   <= n_cnt;
            if (store) begin
                r_prev[pos] <= i_counter_sample;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_fin <= n_fin;
        if (store) begin
            r_chg[pos] <= delta;
        end
    end

endmodule

`default_nettype wire

>>> hdl/cdpm_fifo.sv
// ----------------------------------------------------------------------------
// cdpm_fifo: two-word job queue
// Decouples the intake walk from the divider.
// ----------------------------------------------------------------------------
`default_nettype none

module cdpm_fifo (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  cdpm_pkg::t_job      i_job,
    input  wire logic           i_pop,
    output logic                o_full,
    output logic                o_valid,
    output cdpm_pkg::t_job      o_job
);

    cdpm_pkg::t_job r_mem [2];
    logic           r_wp, r_rp;
    logic [1:0]     r_cnt;

    assign o_full  = r_cnt == 2'd2;
    assign o_valid = r_cnt != 2'd0;
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

endmodule

`default_nettype wire

>>> hdl/cdpm_div.sv
// ----------------------------------------------------------------------------
// cdpm_div: per-mille divider
// Scales one change by 1000, adds half the total and runs a restoring divide,
// one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module cdpm_div (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    input  cdpm_pkg::t_job                    i_job,
    output logic                              o_pop,
    output logic                              o_valid,
    output logic [cdpm_pkg::SHARE_W-1:0]      o_share_per_mille,
    output logic [cdpm_pkg::TOTAL_W-1:0]      o_total_change,
    output logic                              o_run_end
);

    cdpm_pkg::t_div_state r_state, n_state;

    logic [cdpm_pkg::NUM_W-1:0]   r_num;
    logic [cdpm_pkg::TOTAL_W:0]   r_rem;
    logic [cdpm_pkg::TOTAL_W-1:0] r_den;
    logic                         r_last;
    logic [cdpm_pkg::STEP_W-1:0]  r_step;

    logic [cdpm_pkg::NUM_W-1:0]   scaled;
    logic [cdpm_pkg::TOTAL_W:0]   trial;
    logic                         fits;

    assign scaled = cdpm_pkg::NUM_W'(i_job.change) * cdpm_pkg::NUM_W'(cdpm_pkg::PER_MILLE)
                  + cdpm_pkg::NUM_W'(i_job.total >> 1);
    assign trial  = {r_rem[cdpm_pkg::TOTAL_W-1:0], r_num[cdpm_pkg::NUM_W-1]};
    assign fits   = trial >= {1'b0, r_den};

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            cdpm_pkg::DS_IDLE: begin
                if (i_valid) n_state = cdpm_pkg::DS_RUN;
            end
            cdpm_pkg::DS_RUN: begin
                if (r_step == cdpm_pkg::LAST_STEP) n_state = cdpm_pkg::DS_DONE;
            end
            cdpm_pkg::DS_DONE: n_state = cdpm_pkg::DS_IDLE;
            default:           n_state = cdpm_pkg::DS_IDLE;
        endcase
    end

    always_comb begin
        o_pop   = (r_state == cdpm_pkg::DS_IDLE) && i_valid;
        o_valid = r_state == cdpm_pkg::DS_DONE;
    end

    assign o_share_per_mille = r_num[cdpm_pkg::SHARE_W-1:0];
    assign o_total_change    = r_den;
    assign o_run_end         = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cdpm_pkg::DS_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            if (o_pop) begin
                r_step <= '0;
            end else if (r_state == cdpm_pkg::DS_RUN) begin
                r_step <= r_step + cdpm_pkg::STEP_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_num  <= scaled;
            r_rem  <= '0;
            r_den  <= i_job.total;
            r_last <= i_job.last;
        end else if (r_state == cdpm_pkg::DS_RUN) begin
            // shift in one quotient bit, keep the partial remainder
            r_rem <= fits ? (trial - {1'b0, r_den}) : trial;
            r_num <= {r_num[cdpm_pkg::NUM_W-2:0], fits};
        end
    end

endmodule

`default_nettype wire

>>> test/testbench.sv
// ----------------------------------------------------------------------------
// testbench: counter_delta_per_mille_shares
// Sends counter sample sets through the sample inputs, predicts each per-mille
// share from a private copy of the previous samples, and compares every
// strobed share in order. Covers wrap, zero totals, full and overlong sets.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

    localparam int ENTRIES     = cdpm_pkg::MAX_ENTRIES_DEF;
    localparam int STALL_LIMIT = 20000;
    localparam int SAMPLE_W    = cdpm_pkg::SAMPLE_W;
    localparam int TOTAL_W     = cdpm_pkg::TOTAL_W;
    localparam int SHARE_W     = cdpm_pkg::SHARE_W;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = cdpm_pkg::TOTAL_MAX;

    typedef struct packed {
        logic [SHARE_W-1:0] share;
        logic [TOTAL_W-1:0] total;
        logic               last;
    } t_share;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_start;
    logic [SAMPLE_W-1:0] i_counter_sample;
    logic                i_set_end;
    logic                o_busy;
    logic                o_valid;
    logic [SHARE_W-1:0]  o_share_per_mille;
    logic [TOTAL_W-1:0]  o_total_change;
    logic                o_run_end;

    // predictor state
    logic [SAMPLE_W-1:0] prev_sample [ENTRIES];
    logic [SAMPLE_W-1:0] set_change [ENTRIES];
    logic [TOTAL_W-1:0]  set_total;
    int                  set_count;

    t_share expected_shares[$];
    int     error_count;
    int     idle_cycles;
    int     send_gap_pct;

    counter_delta_per_mille_shares uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_start           (i_start),
        .i_counter_sample  (i_counter_sample),
        .i_set_end         (i_set_end),
        .o_busy            (o_busy),
        .o_valid           (o_valid),
        .o_share_per_mille (o_share_per_mille),
        .o_total_change    (o_total_change),
        .o_run_end         (o_run_end)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $time, what);
        error_count++;
    endtask

    // Fold one sample into the predicted set; on set end, queue the shares.
    task automatic predict_shares(input logic [SAMPLE_W-1:0] sample, input logic last);
        logic [SAMPLE_W-1:0] delta;
        logic [TOTAL_W:0]    sum;
        logic [TOTAL_W-1:0]  divisor;
        logic [63:0]         num;
        t_share              item;
        if (set_count < ENTRIES) begin
            delta                  = sample - prev_sample[set_count];
            set_change[set_count]  = delta;
            prev_sample[set_count] = sample;
            sum = {1'b0, set_total} + delta;
            set_total = sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];
            set_count++;
        end
        if (!last) return;
        divisor = (set_total == 0) ? TOTAL_W'(1) : set_total;
        for (int k = 0; k < set_count; k++) begin
            num        = 64'(set_change[k]) * 1000 + 64'(divisor / 2);
            item.share = SHARE_W'(num / 64'(divisor));
            item.total = divisor;
            item.last  = (k + 1 == set_count);
            expected_shares.push_back(item);
        end
        set_count = 0;
        set_total = '0;
    endtask

    // Send one word: random leading gap, hold start until the block takes it.
    task automatic send_sample(input logic [SAMPLE_W-1:0] sample, input logic last);
        while ($urandom_range(99) < send_gap_pct) begin
            i_start <= 1'b0;
            @(posedge i_clk);
        end
        i_start          <= 1'b1;
        i_counter_sample <= sample;
        i_set_end        <= last;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        predict_shares(sample, last);
    endtask

    // Hold off until every predicted share has been seen.
    task automatic drain_shares();
        i_start <= 1'b0;
        while (expected_shares.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
    endtask

    // Check every strobed share against the oldest prediction.
    always @(posedge i_clk) begin
        t_share head;
        if (i_rst_n && o_valid) begin
            if (expected_shares.size() == 0) begin
                report_mismatch("share with nothing expected");
            end else begin
                head = expected_shares.pop_front();
                if (o_share_per_mille !== head.share)
                    report_mismatch($sformatf("share %0d, want %0d",
                                              o_share_per_mille, head.share));
                if (o_total_change !== head.total)
                    report_mismatch($sformatf("total %0d, want %0d",
                                              o_total_change, head.total));
                if (o_run_end !== head.last)
                    report_mismatch($sformatf("run end %0b, want %0b",
                                              o_run_end, head.last));
            end
        end
    end

    // Watchdog: count cycles with neither an accepted word nor a share.
    always @(posedge i_clk) begin
        if ((i_start && !o_busy) || o_valid) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic send_set(input int len);
        for (int k = 0; k < len; k++)
            send_sample($urandom, k == len - 1);
    endtask

    task automatic test_extremes();
        send_sample('0, 1'b1);                    // zero total
        send_sample(32'hFFFF_FFFF, 1'b1);          // single entry takes all
        send_sample(32'h0000_0005, 1'b0);          // entry 0 wraps forward
        send_sample(32'hFFFF_FFFF, 1'b1);
        send_sample(32'h0000_0005, 1'b0);          // unchanged: zero total
        send_sample(32'hFFFF_FFFF, 1'b1);
        send_sample(32'h5555_5555, 1'b0);
        send_sample(32'hAAAA_AAAA, 1'b1);
        drain_shares();
    endtask

    task automatic test_full_sets();
        for (int k = 0; k < ENTRIES; k++)
            send_sample(32'hFFFF_FFFF - k, k == ENTRIES - 1);
        // overlong set: the extra words are dropped, set end still closes it
        for (int k = 0; k < ENTRIES + 3; k++)
            send_sample(k[0] ? 32'h8000_0000 : 32'h7FFF_FFFF, k == ENTRIES + 2);
        drain_shares();
    endtask

    task automatic test_random(input int words);
        int sent;
        int len;
        sent = 0;
        while (sent < words) begin
            // mostly short sets, some full and overlong
            case ($urandom_range(9))
                0:       len = ENTRIES + $urandom_range(3);
                1:       len = ENTRIES;
                default: len = $urandom_range(1, 4);
            endcase
            if ($urandom_range(3) == 0) begin
                // small deltas around the previous samples
                for (int k = 0; k < len; k++)
                    send_sample(prev_sample[k < ENTRIES ? k : 0] + $urandom_range(50),
                                k == len - 1);
            end else begin
                send_set(len);
            end
            sent += len;
        end
        drain_shares();
    endtask

    initial begin
        error_count      = 0;
        idle_cycles      = 0;
        send_gap_pct     = 0;
        set_total        = '0;
        set_count        = 0;
        foreach (prev_sample[k]) prev_sample[k] = '0;
        i_rst_n          = 1'b0;
        i_start          = 1'b0;
        i_counter_sample = '0;
        i_set_end        = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_extremes();
        test_full_sets();
        test_random(100);
        send_gap_pct = 70;
        test_random(100);
        send_gap_pct = 7;
        test_random(100);
        send_gap_pct = 0;
        test_random(90);

        drain_shares();
        if (error_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire

>>> files.f
hdl/cdpm_pkg.sv
hdl/cdpm_front.sv
hdl/cdpm_fifo.sv
hdl/cdpm_div.sv
hdl/counter_delta_per_mille_shares.sv
test/testbench.sv
